/* design/quarter_hour_demand_limiter_unit_macros.svh */
// ----------------------------------------------------------------------------
// quarter_hour_demand_limiter_unit_macros.svh
// Assertion macros shared by the checker of the demand limiter.
// ----------------------------------------------------------------------------
`ifndef QUARTER_HOUR_DEMAND_LIMITER_UNIT_MACROS_SVH
`define QUARTER_HOUR_DEMAND_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define QHDL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define QHDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/qhdl_pkg.sv */
// ----------------------------------------------------------------------------
// qhdl_pkg
// Types and constants of the quarter hour demand limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package qhdl_pkg;

  localparam logic [9:0]  QUARTER_SECONDS = 10'd900;
  localparam logic [5:0]  MINUTE_LAST     = 6'd59;
  localparam logic [5:0]  MINUTE_SECONDS  = 6'd60;
  localparam logic [25:0] PEAK_RESET      = 26'd2250000;
  localparam logic [15:0] RATE_RESET      = 16'd12000;
  localparam logic signed [27:0] ACC_MAX  = 28'sd67108863;
  localparam logic signed [27:0] ACC_MIN  = -28'sd67108864;

  // Quarter boundaries in minutes
  localparam logic [5:0] Q1_MINUTE = 6'd15;
  localparam logic [5:0] Q2_MINUTE = 6'd30;
  localparam logic [5:0] Q3_MINUTE = 6'd45;

  // Configuration register indexes
  localparam logic REG_BASE_PEAK = 1'b0;
  localparam logic REG_MAX_RATE  = 1'b1;

  // Output tdata layout
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [15:0] returned_watts;
    logic [15:0] delivered_watts;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [3:0]  month;
  } item_t;

  typedef struct packed {
    logic [25:0] base_peak;
    logic [15:0] max_rate_per_second;
  } cfg_t;

  typedef struct packed {
    logic [26:0] acc;       // two's complement
    logic [25:0] peak;
    logic [1:0]  quarter;
    logic [3:0]  month;
    logic [9:0]  last_on;
  } state_t;

  typedef struct packed {
    logic [9:0]  closed_switch_second;
    logic [26:0] closed_energy;
    logic        quarter_closed;
    logic [25:0] month_peak;
    logic [26:0] quarter_energy;
    logic [9:0]  seconds_in_quarter;
    logic        load_on;
  } result_t;

endpackage

`default_nettype wire

/* design/qhdl_step.sv */
// ----------------------------------------------------------------------------
// qhdl_step
// One meter reading against the stored state: quarter close, month reload,
// saturating accumulate and the worst-case load decision.
// ----------------------------------------------------------------------------
`default_nettype none

module qhdl_step (
  input  qhdl_pkg::state_t  st_i,
  input  qhdl_pkg::item_t   item_i,
  input  qhdl_pkg::cfg_t    cfg_i,
  output qhdl_pkg::state_t  st_o,
  output qhdl_pkg::result_t res_o
);

  logic [5:0]  min_sat, sec_sat, q_start;
  logic [1:0]  quarter;
  logic [3:0]  min_in_q;
  logic [9:0]  secs, remaining;
  logic        closed, month_new, load;
  logic signed [27:0] acc_old, acc_base, sum, acc_clamped;
  logic [26:0] acc_new;
  logic [25:0] peak_raised, peak_new, product;
  logic signed [28:0] worst, peak_ext;
  logic [9:0]  last_on_new;

  always_comb begin
    min_sat = (item_i.minute > qhdl_pkg::MINUTE_LAST) ? qhdl_pkg::MINUTE_LAST
                                                        : item_i.minute;
    sec_sat = (item_i.second > qhdl_pkg::MINUTE_LAST) ? qhdl_pkg::MINUTE_LAST
                                                        : item_i.second;
    if (min_sat >= qhdl_pkg::Q3_MINUTE) begin
      quarter = 2'd3;
      q_start = qhdl_pkg::Q3_MINUTE;
    end else if (min_sat >= qhdl_pkg::Q2_MINUTE) begin
      quarter = 2'd2;
      q_start = qhdl_pkg::Q2_MINUTE;
    end else if (min_sat >= qhdl_pkg::Q1_MINUTE) begin
      quarter = 2'd1;
      q_start = qhdl_pkg::Q1_MINUTE;
    end else begin
      quarter = 2'd0;
      q_start = 6'd0;
    end
    min_in_q = 4'(min_sat - q_start);
    secs     = ({6'd0, min_in_q} * {4'd0, qhdl_pkg::MINUTE_SECONDS}) + {4'd0, sec_sat};

    closed    = (quarter != st_i.quarter);
    month_new = (item_i.month != st_i.month);

    // Raise the peak with the closed quarter first, then reload on a new month
    acc_old     = {st_i.acc[26], st_i.acc};
    peak_raised = (closed && (acc_old > $signed({2'b00, st_i.peak})))
                  ? st_i.acc[25:0] : st_i.peak;
    peak_new    = month_new ? cfg_i.base_peak : peak_raised;

    acc_base = closed ? 28'sd0 : acc_old;
    sum      = acc_base + $signed({12'd0, item_i.delivered_watts})
                        - $signed({12'd0, item_i.returned_watts});
    if (sum > qhdl_pkg::ACC_MAX) begin
      acc_clamped = qhdl_pkg::ACC_MAX;
    end else if (sum < qhdl_pkg::ACC_MIN) begin
      acc_clamped = qhdl_pkg::ACC_MIN;
    end else begin
      acc_clamped = sum;
    end
    acc_new = acc_clamped[26:0];

    remaining = qhdl_pkg::QUARTER_SECONDS - secs;
    // 16 x 10 bits, at most 58981500, fits in 26 bits
    product   = {10'd0, cfg_i.max_rate_per_second} * {16'd0, remaining};
    worst     = $signed({{2{acc_new[26]}}, acc_new}) + $signed({3'b000, product});
    peak_ext  = $signed({3'b000, peak_new});
    load      = !(worst > peak_ext);

    if (load) begin
      last_on_new = secs;
    end else if (closed) begin
      last_on_new = 10'd0;
    end else begin
      last_on_new = st_i.last_on;
    end

    st_o.acc     = acc_new;
    st_o.peak    = peak_new;
    st_o.quarter = quarter;
    st_o.month   = item_i.month;
    st_o.last_on = last_on_new;

    res_o.load_on              = load;
    res_o.seconds_in_quarter   = secs;
    res_o.quarter_energy       = acc_new;
    res_o.month_peak           = peak_new;
    res_o.quarter_closed       = closed;
    res_o.closed_energy        = closed ? st_i.acc : 27'd0;
    res_o.closed_switch_second = closed ? st_i.last_on : 10'd0;
  end

endmodule

`default_nettype wire

/* design/quarter_hour_demand_limiter_unit.sv */
// ----------------------------------------------------------------------------
// quarter_hour_demand_limiter_unit
// Quarter hour energy tracker and deferrable load switch for a power meter.
// ----------------------------------------------------------------------------
// One reading per beat; a new reading is taken every clock cycle while the
// output side keeps taking results. Its result passes the input register and
// then the result register before it is presented on the master side. The
// reading is latched in an input register, then a single registered step
// updates the quarter energy, the monthly peak and the load decision and
// writes the result register, so the throughput is one beat per cycle as long
// as the output side keeps taking results. Configuration writes are registered
// and are used by the next reading processed.
`default_nettype none

module quarter_hour_demand_limiter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Readings: month[3:0], minute[9:4], second[15:10],
  // delivered_watts[31:16], returned_watts[47:32]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,
  // Results: load_on[0], seconds_in_quarter[10:1], quarter_energy[37:11],
  // month_peak[63:38], closed_energy[90:64], closed_switch_second[100:91]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  // quarter_closed[0]
  output logic         m_tuser,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [25:0]  cfg_data_i
);

  logic                in_valid_q;
  qhdl_pkg::item_t     item_q;
  logic                out_valid_q;
  qhdl_pkg::result_t   res_q, res_d;
  qhdl_pkg::state_t    state_q, state_d;
  qhdl_pkg::cfg_t      cfg_q;
  logic                advance;

  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      item_q <= qhdl_pkg::item_t'(s_tdata);
    end
  end

  qhdl_step u_step (
    .st_i   (state_q),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .st_o   (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.acc     <= 27'd0;
      state_q.peak    <= qhdl_pkg::PEAK_RESET;
      state_q.quarter <= 2'd0;
      state_q.month   <= 4'd0;
      state_q.last_on <= 10'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_peak           <= qhdl_pkg::PEAK_RESET;
      cfg_q.max_rate_per_second <= qhdl_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qhdl_pkg::REG_BASE_PEAK: cfg_q.base_peak           <= cfg_data_i;
        qhdl_pkg::REG_MAX_RATE:  cfg_q.max_rate_per_second <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = res_q.quarter_closed;
  assign m_tdata  = {3'b000,
                     res_q.closed_switch_second,
                     res_q.closed_energy,
                     res_q.month_peak,
                     res_q.quarter_energy,
                     res_q.seconds_in_quarter,
                     res_q.load_on};

endmodule

`default_nettype wire

/* design/qhdl_checker.sv */
// ----------------------------------------------------------------------------
// qhdl_checker
// Port-level checks of the demand limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quarter_hour_demand_limiter_unit_macros.svh"

module qhdl_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tuser
);

  logic [9:0] secs_f;

  assign secs_f = m_tdata[10:1];

  // A stalled result beat holds
  `QHDL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Input backpressure only when both stages hold a beat and output stalls
  `QHDL_ASSERT_NOW(a_in_stall, clk_i, rst_ni, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

  // Seconds stay within a quarter
  `QHDL_ASSERT_NOW(a_secs_range, clk_i, rst_ni, m_tvalid, secs_f < 10'd900, "seconds_in_quarter out of range")

  // Closed-quarter fields are zero when no quarter closed
  `QHDL_ASSERT_NOW(a_closed_zero, clk_i, rst_ni, m_tvalid && !m_tuser, m_tdata[100:64] == 37'd0, "closed fields set without quarter close")

endmodule

bind quarter_hour_demand_limiter_unit qhdl_checker u_qhdl_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quarter hour demand limiter. Meter readings go
// in as stream beats, each accepted beat is run through a behavioral model of
// the quarter energy, monthly peak and load decision, and every result beat
// is compared field by field against the oldest prediction. Directed corner
// readings, register settings at their extremes, an accumulator saturation
// run and random meter sequences are applied with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic              load_on;
    logic [9:0]        secs;
    logic signed [26:0] energy;
    logic [25:0]       peak;
    logic              closed;
    logic signed [26:0] closed_energy;
    logic [9:0]        closed_sw;
  } limiter_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = qhdl_pkg::REG_BASE_PEAK;
  logic [25:0]  cfg_data_i = '0;

  quarter_hour_demand_limiter_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),    // month, minute, second, delivered, returned
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),    // load_on, secs, energy, peak, closed energy/second
    .m_tuser    (m_tuser),    // quarter_closed
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Limiter state and registers as seen by the model
  logic [25:0] base_peak_cfg = qhdl_pkg::PEAK_RESET;
  logic [15:0] max_rate_cfg = qhdl_pkg::RATE_RESET;
  longint      quarter_ws = 0;
  logic [25:0] peak_ws = qhdl_pkg::PEAK_RESET;
  logic [1:0]  quarter_q = '0;
  logic [3:0]  month_q = '0;
  logic [9:0]  last_on_s = '0;

  limiter_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int stall_left = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // Meter clock for well-formed sequences
  int         seq_month = 1;
  int         seq_second_of_hour = 0;

  function automatic limiter_result_t predict_reading(input qhdl_pkg::item_t r);
    limiter_result_t res;
    int     mnt, sec, q, secs;
    longint worst;
    mnt = (r.minute > qhdl_pkg::MINUTE_LAST) ? int'(qhdl_pkg::MINUTE_LAST) : int'(r.minute);
    sec = (r.second > qhdl_pkg::MINUTE_LAST) ? int'(qhdl_pkg::MINUTE_LAST) : int'(r.second);
    q = mnt / int'(qhdl_pkg::Q1_MINUTE);
    res.closed = 1'b0;
    res.closed_energy = '0;
    res.closed_sw = '0;
    if (q != int'(quarter_q)) begin
      quarter_q = q[1:0];
      res.closed = 1'b1;
      res.closed_energy = quarter_ws[26:0];
      res.closed_sw = last_on_s;
      // never lower the peak, a negative quarter cannot beat it
      if (quarter_ws > longint'(peak_ws)) peak_ws = quarter_ws[25:0];
      quarter_ws = 0;
      last_on_s = '0;
    end
    // raise first, then reload on a new month
    if (r.month != month_q) begin
      month_q = r.month;
      peak_ws = base_peak_cfg;
    end
    secs = (mnt - int'(qhdl_pkg::Q1_MINUTE) * q) * int'(qhdl_pkg::MINUTE_SECONDS) + sec;
    quarter_ws = quarter_ws + longint'(r.delivered_watts) - longint'(r.returned_watts);
    if (quarter_ws > longint'(qhdl_pkg::ACC_MAX)) quarter_ws = longint'(qhdl_pkg::ACC_MAX);
    if (quarter_ws < longint'(qhdl_pkg::ACC_MIN)) quarter_ws = longint'(qhdl_pkg::ACC_MIN);
    worst = quarter_ws + longint'(max_rate_cfg) *
            longint'(int'(qhdl_pkg::QUARTER_SECONDS) - secs);
    res.load_on = (worst <= longint'(peak_ws));
    if (res.load_on) last_on_s = secs[9:0];
    res.secs = secs[9:0];
    res.energy = quarter_ws[26:0];
    res.peak = peak_ws;
    return res;
  endfunction

  function automatic qhdl_pkg::item_t make_reading(input int mon, input int mnt, input int sec,
                                                   input int del, input int ret);
    qhdl_pkg::item_t r;
    r.month = mon[3:0];
    r.minute = mnt[5:0];
    r.second = sec[5:0];
    r.delivered_watts = del[15:0];
    r.returned_watts = ret[15:0];
    return r;
  endfunction

  task automatic send_reading(input qhdl_pkg::item_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= r;
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(predict_reading(r));
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [25:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == qhdl_pkg::REG_BASE_PEAK) base_peak_cfg = val;
    else max_rate_cfg = val[15:0];
  endtask

  task automatic run_meter_sequence(input int n, input int noise_pct, input int max_jump);
    qhdl_pkg::item_t r;
    int    del, ret;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        r = make_reading($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        if ($urandom_range(0, 9) == 0)
          seq_second_of_hour = (seq_second_of_hour + $urandom_range(1, max_jump)) % 3600;
        else
          seq_second_of_hour = (seq_second_of_hour + 1) % 3600;
        if ($urandom_range(0, 199) == 0) seq_month = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: begin del = $urandom_range(0, 3000); ret = 0; end
          1: begin del = $urandom_range(0, 65535); ret = 0; end
          2: begin del = 0; ret = $urandom_range(0, 5000); end
          default: begin
            del = $urandom_range(0, 65535);
            ret = $urandom_range(0, 65535);
          end
        endcase
        r = make_reading(seq_month, seq_second_of_hour / 60, seq_second_of_hour % 60, del, ret);
      end
      send_reading(r);
    end
  endtask

  task automatic test_directed_corners();
    gaps_on = 1'b0;
    send_reading(make_reading(0, 0, 0, 0, 0));          // stored month, quarter 0
    send_reading(make_reading(1, 0, 0, 65535, 0));      // first real month
    send_reading(make_reading(1, 14, 59, 1000, 0));
    send_reading(make_reading(1, 15, 0, 0, 65535));     // close quarter 0
    send_reading(make_reading(1, 29, 59, 0, 65535));
    send_reading(make_reading(1, 30, 0, 0, 0));         // close a negative quarter
    send_reading(make_reading(12, 45, 0, 65535, 65535)); // quarter and month together
    send_reading(make_reading(13, 63, 63, 1, 0));       // out of range month, clip min/sec
    send_reading(make_reading(15, 60, 60, 0, 1));
    send_reading(make_reading(0, 59, 59, 65535, 0));
    send_reading(make_reading(15, 0, 0, 0, 0));         // wrap to quarter 0, new month
    send_reading(make_reading(5, 14, 58, 0, 0));
    send_reading(make_reading(5, 14, 59, 0, 0));        // late in quarter, load on
    send_reading(make_reading(5, 7, 30, 200, 0));
    gaps_on = 1'b1;
    send_reading(make_reading(5, 16, 0, 40000, 0));
    send_reading(make_reading(5, 16, 1, 40000, 0));
    send_reading(make_reading(5, 20, 0, 0, 40000));
    settle();
  endtask

  task automatic test_register_settings();
    logic [25:0] peaks[6];
    logic [15:0] rates[6];
    peaks = '{26'd0, 26'h3FFFFFF, 26'd0, 26'h3FFFFFF, 26'd500000, qhdl_pkg::PEAK_RESET};
    rates = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd3000, qhdl_pkg::RATE_RESET};
    for (int p = 0; p < 6; p++) begin
      write_reg(qhdl_pkg::REG_BASE_PEAK, peaks[p]);
      write_reg(qhdl_pkg::REG_MAX_RATE, {10'd0, rates[p]});
      // force a reload of the peak
      seq_month = (seq_month % 12) + 1;
      gaps_on = p[0];
      run_meter_sequence(20, 5, 120);
    end
    settle();
  endtask

  task automatic test_accumulator_saturation();
    seq_month = (seq_month % 12) + 1;
    gaps_on = 1'b1;
    send_reading(make_reading(seq_month, 0, 0, 0, 0));
    for (int i = 0; i < 1030; i++) begin
      gaps_on = i[9];
      send_reading(make_reading(seq_month, $urandom_range(0, 14), $urandom_range(0, 59),
                                65535 - $urandom_range(0, 31), $urandom_range(0, 31)));
    end
    send_reading(make_reading(seq_month, 15, 0, 0, 0));
    settle();
  endtask

  task automatic test_random_readings();
    for (int c = 0; c < 2; c++) begin
      gaps_on = (c % 2) != 0;
      run_meter_sequence(20, 10, 300);
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_register_settings();
    test_accumulator_saturation();
    test_random_readings();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each beat, then decide the next stall
  always @(posedge clk_i) begin : result_side
    limiter_result_t want;
    int stall_len;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no reading pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("load_on", want.load_on, m_tdata[0]);
        check_field("seconds_in_quarter", want.secs, m_tdata[10:1]);
        check_field("quarter_energy", want.energy, $signed(m_tdata[37:11]));
        check_field("month_peak", want.peak, m_tdata[63:38]);
        check_field("quarter_closed", want.closed, m_tuser);
        check_field("closed_energy", want.closed_energy, $signed(m_tdata[90:64]));
        check_field("closed_switch_second", want.closed_sw, m_tdata[100:91]);
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (cycles[10:9])
        2'd0: stall_len = 0;
        2'd1: stall_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        2'd2: stall_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        default: stall_len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 20) : 0;
      endcase
      m_tready <= (stall_len == 0);
      stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
    end
  end

endmodule
